/* src/slpw_pkg.sv */
// Shared widths, codes and item types for the spherical lens pixel warp unit.
`default_nettype none
package slpw_pkg;

  // Fraction bits of the internal normalised coordinates.
  localparam int FRAC_BITS = 24;

  // Internal widths for the fraction format above.
  localparam int NRMW = 36;  // normalised pixel, unsigned
  localparam int NW   = 38;  // signed offset-corrected coordinate
  localparam int AXW  = 37;  // magnitude of that coordinate
  localparam int R2W  = 51;  // radius squared
  localparam int KW   = 32;  // distortion coefficient
  localparam int QW   = 49;  // reciprocal quotient and divisor
  localparam int SW   = 37;  // square-root scale
  localparam int RMW  = 39;  // square-root partial remainder
  localparam int TW   = 52;  // shifted-back coordinate
  localparam int OW   = 24;  // output pixel coordinate

  // Configuration register indexes.
  localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [2:0] REG_INVERSE_WIDTH = 3'd1;
  localparam logic [2:0] REG_X_OFFSET      = 3'd2;
  localparam logic [2:0] REG_Y_OFFSET      = 3'd3;
  localparam logic [2:0] REG_DIST_COEFF    = 3'd4;

  // Command codes.
  localparam logic CMD_DISTORT   = 1'b0;
  localparam logic CMD_UNDISTORT = 1'b1;

  // Coordinate data ahead of the denominator stage.
  typedef struct packed {
    logic           cmd;
    logic           sx;
    logic           sy;
    logic [AXW-1:0] ax;
    logic [AXW-1:0] ay;
  } pre_t;

  // Data that travels beside the reciprocal and square-root cells.
  typedef struct packed {
    logic           sx;
    logic           sy;
    logic           zs;   // scale forced to zero
    logic           inv;  // undistort with non-positive denominator
    logic [AXW-1:0] ax;
    logic [AXW-1:0] ay;
  } side_t;

  // One result word.
  typedef struct packed {
    logic          inv;
    logic [OW-1:0] y;
    logic [OW-1:0] x;
  } res_t;

endpackage
`default_nettype wire

/* src/slpw_mul.sv */
// Two-stage multiplier that splits each operand at bit 32 into four partial products.
`default_nettype none
module slpw_mul #(
  parameter int AW = 37,
  parameter int BW = 37
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [AW-1:0]    a,
  input  wire logic [BW-1:0]    b,
  output logic      [AW+BW-1:0] p
);
  localparam int LO = 32;
  localparam int AH = AW - LO;
  localparam int BH = BW - LO;
  localparam int PW = AW + BW;

  logic [2*LO-1:0]  ll_r;
  logic [LO+BH-1:0] lh_r;
  logic [AH+LO-1:0] hl_r;
  logic [AH+BH-1:0] hh_r;
  logic [PW-1:0]    p_r;
  logic [PW-1:0]    p_nxt;

  // First stage: the four partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= a[LO-1:0] * b[LO-1:0];
      lh_r <= a[LO-1:0] * b[BW-1:LO];
      hl_r <= a[AW-1:LO] * b[LO-1:0];
      hh_r <= a[AW-1:LO] * b[BW-1:LO];
    end
  end

  // Second stage: align and add them.
  always_comb begin
    p_nxt = PW'(ll_r) + (PW'(lh_r) << LO) + (PW'(hl_r) << LO) + (PW'(hh_r) << (2 * LO));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end

  assign p = p_r;
endmodule
`default_nettype wire

/* src/slpw_div_cell.sv */
// One restoring-division cell of the reciprocal chain: one quotient bit.
`default_nettype none
module slpw_div_cell #(
  parameter int QB = 0
) (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [slpw_pkg::QW-1:0]    rem_i,
  input  wire logic [slpw_pkg::QW-1:0]    q_i,
  input  wire logic [slpw_pkg::QW-1:0]    d_i,
  input  wire slpw_pkg::side_t            side_i,
  output logic      [slpw_pkg::QW-1:0]    rem_o,
  output logic      [slpw_pkg::QW-1:0]    q_o,
  output logic      [slpw_pkg::QW-1:0]    d_o,
  output slpw_pkg::side_t                 side_o
);
  import slpw_pkg::*;

  // The dividend is a single one at the top quotient bit.
  localparam logic LEAD = (QB == QW - 1) ? 1'b1 : 1'b0;

  logic [QW:0]   sh;
  logic [QW:0]   diff;
  logic          ge;
  logic [QW-1:0] rem_nxt;
  logic [QW-1:0] q_nxt;
  logic [QW-1:0] rem_r;
  logic [QW-1:0] q_r;
  logic [QW-1:0] d_r;
  side_t         side_r;

  // Trial subtraction of the divisor from the shifted remainder.
  always_comb begin
    sh      = {rem_i, LEAD};
    diff    = sh - {1'b0, d_i};
    ge      = (sh >= {1'b0, d_i});
    rem_nxt = ge ? diff[QW-1:0] : sh[QW-1:0];
    q_nxt   = q_i;
    q_nxt[QB] = ge;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      q_r    <= q_nxt;
      d_r    <= d_i;
      side_r <= side_i;
    end
  end

  assign rem_o  = rem_r;
  assign q_o    = q_r;
  assign d_o    = d_r;
  assign side_o = side_r;
endmodule
`default_nettype wire

/* src/slpw_sqrt_cell.sv */
// One digit-by-digit square-root cell: one root bit from two radicand bits.
`default_nettype none
module slpw_sqrt_cell #(
  parameter int J = 0
) (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [slpw_pkg::QW-1:0]    q_i,
  input  wire logic [slpw_pkg::RMW-1:0]   rem_i,
  input  wire logic [slpw_pkg::SW-1:0]    root_i,
  input  wire slpw_pkg::side_t            side_i,
  output logic      [slpw_pkg::QW-1:0]    q_o,
  output logic      [slpw_pkg::RMW-1:0]   rem_o,
  output logic      [slpw_pkg::SW-1:0]    root_o,
  output slpw_pkg::side_t                 side_o
);
  import slpw_pkg::*;

  localparam int XW = 2 * SW;

  logic [XW-1:0]    x;
  logic [RMW+1:0]   sh;
  logic [RMW+1:0]   trial;
  logic [RMW+1:0]   diff;
  logic             ge;
  logic [RMW-1:0]   rem_nxt;
  logic [SW-1:0]    root_nxt;
  logic [QW-1:0]    q_r;
  logic [RMW-1:0]   rem_r;
  logic [SW-1:0]    root_r;
  side_t            side_r;

  // The radicand is the quotient moved up by the fraction bits.
  always_comb begin
    x        = XW'({q_i, {FRAC_BITS{1'b0}}});
    sh       = {rem_i, x[2*J+1 -: 2]};
    trial    = (RMW + 2)'({root_i, 2'b01});
    diff     = sh - trial;
    ge       = (sh >= trial);
    rem_nxt  = ge ? diff[RMW-1:0] : sh[RMW-1:0];
    root_nxt = {root_i[SW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r    <= q_i;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r <= side_i;
    end
  end

  assign q_o    = q_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign side_o = side_r;
endmodule
`default_nettype wire

/* src/spherical_lens_pixel_warp_unit.sv */
// Top level of the spherical lens pixel warp: configuration, pipeline and output skid.
//
//  Channel  Direction  Handshake            Contents
//  in_      slave      in_tvalid/in_tready  tdata: pixel_x, pixel_y; tuser: command
//  out_     master     out_tvalid/out_tready tdata: warped_x, warped_y; tuser: invalid
//  cfg_     APB slave  psel/penable/pready  five registers at byte addresses 0 to 16
//
// One word is taken per clock while in_tready is high; its result reaches out_ after the front
// stages, the reciprocal chain of 49 cells, the square-root chain of 37 and the back stages.
// rst_n clears the valid bits and the output and skid valid flags, and reloads the configuration.
// A stalled output fills the skid register; in_tready then drops and the whole pipeline holds.
`default_nettype none
module spherical_lens_pixel_warp_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,    // pixel_x [19:0], pixel_y [39:20]
  input  wire logic        in_tuser,    // command [0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [47:0] out_tdata,   // warped_x [23:0], warped_y [47:24]
  output logic             out_tuser,   // invalid [0]
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);
  import slpw_pkg::*;

  localparam int DIVN = QW;
  localparam int SQN  = SW;
  localparam int LAT  = 9 + DIVN + SQN + 6;

  // Configuration registers.
  logic [11:0]        width_r;
  logic [31:0]        invw_r;
  logic signed [27:0] xoff_r;
  logic signed [27:0] yoff_r;
  logic [KW-1:0]      kco_r;
  logic [2:0]         cfg_idx;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 12'd640;
      invw_r  <= 32'd6710886;
      xoff_r  <= 28'sd8388608;
      yoff_r  <= 28'sd6291456;
      kco_r   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_IMAGE_WIDTH:   width_r <= cfg_pwdata[11:0];
        REG_INVERSE_WIDTH: invw_r  <= cfg_pwdata;
        REG_X_OFFSET:      xoff_r  <= cfg_pwdata[27:0];
        REG_Y_OFFSET:      yoff_r  <= cfg_pwdata[27:0];
        REG_DIST_COEFF:    kco_r   <= cfg_pwdata;
        default:           ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (cfg_idx)
      REG_IMAGE_WIDTH:   cfg_prdata = {20'd0, width_r};
      REG_INVERSE_WIDTH: cfg_prdata = invw_r;
      REG_X_OFFSET:      cfg_prdata = 32'(xoff_r);
      REG_Y_OFFSET:      cfg_prdata = 32'(yoff_r);
      REG_DIST_COEFF:    cfg_prdata = kco_r;
      default:           cfg_prdata = '0;
    endcase
  end

  // Pipeline enable and valid bits.
  logic           en;
  logic [LAT-1:0] vld_r;
  logic           skid_valid_r;
  logic           out_valid_r;

  assign en        = !skid_valid_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // Normalise by the inverse width.
  logic [51:0]     mx1;
  logic [51:0]     my1;
  logic            cmd1_r;
  logic [NRMW-1:0] nrmx1_r;
  logic [NRMW-1:0] nrmy1_r;

  assign mx1 = 52'(in_tdata[19:0]) * 52'(invw_r);
  assign my1 = 52'(in_tdata[39:20]) * 52'(invw_r);

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1_r  <= in_tuser;
      nrmx1_r <= mx1[51:40-FRAC_BITS];
      nrmy1_r <= my1[51:40-FRAC_BITS];
    end
  end

  // Move to the distortion centre.
  logic                 cmd2_r;
  logic signed [NW-1:0] nx2_r;
  logic signed [NW-1:0] ny2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cmd2_r <= cmd1_r;
      nx2_r  <= $signed({2'b00, nrmx1_r}) - NW'(xoff_r);
      ny2_r  <= $signed({2'b00, nrmy1_r}) - NW'(yoff_r);
    end
  end

  // Sign and magnitude.
  pre_t            pre3_r;
  logic [NW-1:0]   absx2;
  logic [NW-1:0]   absy2;

  assign absx2 = nx2_r[NW-1] ? NW'(-nx2_r) : NW'(nx2_r);
  assign absy2 = ny2_r[NW-1] ? NW'(-ny2_r) : NW'(ny2_r);

  always_ff @(posedge clk) begin
    if (en) begin
      pre3_r.cmd <= cmd2_r;
      pre3_r.sx  <= nx2_r[NW-1];
      pre3_r.sy  <= ny2_r[NW-1];
      pre3_r.ax  <= absx2[AXW-1:0];
      pre3_r.ay  <= absy2[AXW-1:0];
    end
  end

  // Squares of the two magnitudes.
  logic [2*AXW-1:0] sqx;
  logic [2*AXW-1:0] sqy;

  slpw_mul #(.AW(AXW), .BW(AXW)) u_sqx (
    .clk(clk), .en(en), .a(pre3_r.ax), .b(pre3_r.ax), .p(sqx)
  );
  slpw_mul #(.AW(AXW), .BW(AXW)) u_sqy (
    .clk(clk), .en(en), .a(pre3_r.ay), .b(pre3_r.ay), .p(sqy)
  );

  pre_t pre_r [0:4];

  always_ff @(posedge clk) begin
    if (en) begin
      pre_r[0] <= pre3_r;
      pre_r[1] <= pre_r[0];
      pre_r[2] <= pre_r[1];
      pre_r[3] <= pre_r[2];
      pre_r[4] <= pre_r[3];
    end
  end

  // Radius squared.
  logic [R2W-1:0] r2_r;
  logic           tiny6_r;
  logic           tiny7_r;
  logic           tiny8_r;
  logic [R2W-1:0] r2_nxt;

  assign r2_nxt = R2W'(sqx[2*AXW-1:FRAC_BITS]) + R2W'(sqy[2*AXW-1:FRAC_BITS]);

  always_ff @(posedge clk) begin
    if (en) begin
      r2_r    <= r2_nxt;
      tiny6_r <= (r2_nxt == '0);
      tiny7_r <= tiny6_r;
      tiny8_r <= tiny7_r;
    end
  end

  // k times r2.
  logic [KW+R2W:0] kp;

  slpw_mul #(.AW(KW + 1), .BW(R2W)) u_kr2 (
    .clk(clk), .en(en), .a({1'b0, kco_r}), .b(r2_r), .p(kp)
  );

  // Denominator and its special cases.
  localparam int DW = 62;
  logic [DW-1:0] kr2e;
  logic [DW-1:0] one_fx;
  logic [DW-1:0] den;
  logic          dpos;
  logic          big;
  logic [QW-1:0] d9_r;
  side_t         side9_r;

  assign kr2e   = DW'(kp[KW+R2W:FRAC_BITS]);
  assign one_fx = DW'(1) << FRAC_BITS;
  assign den    = (pre_r[4].cmd == CMD_UNDISTORT) ? one_fx - kr2e : one_fx + kr2e;
  assign dpos   = !den[DW-1] && (den != '0);
  assign big    = dpos && (den > (DW'(1) << (2 * FRAC_BITS)));

  always_ff @(posedge clk) begin
    if (en) begin
      d9_r        <= (dpos && !big) ? den[QW-1:0] : QW'(1);
      side9_r.sx  <= pre_r[4].sx;
      side9_r.sy  <= pre_r[4].sy;
      side9_r.ax  <= pre_r[4].ax;
      side9_r.ay  <= pre_r[4].ay;
      side9_r.zs  <= tiny8_r || !dpos || big;
      side9_r.inv <= (pre_r[4].cmd == CMD_UNDISTORT) && !dpos && !tiny8_r;
    end
  end

  // Reciprocal chain: one quotient bit per cell.
  logic [QW-1:0] drem_w [0:DIVN];
  logic [QW-1:0] dq_w   [0:DIVN];
  logic [QW-1:0] dd_w   [0:DIVN];
  side_t         dside_w [0:DIVN];

  assign drem_w[0]  = '0;
  assign dq_w[0]    = '0;
  assign dd_w[0]    = d9_r;
  assign dside_w[0] = side9_r;

  for (genvar gi = 0; gi < DIVN; gi++) begin : g_div
    slpw_div_cell #(.QB(DIVN - 1 - gi)) u_cell (
      .clk(clk), .en(en),
      .rem_i(drem_w[gi]), .q_i(dq_w[gi]), .d_i(dd_w[gi]), .side_i(dside_w[gi]),
      .rem_o(drem_w[gi+1]), .q_o(dq_w[gi+1]), .d_o(dd_w[gi+1]), .side_o(dside_w[gi+1])
    );
  end

  // Square-root chain: one root bit per cell.
  logic [QW-1:0]  sq_w    [0:SQN];
  logic [RMW-1:0] srem_w  [0:SQN];
  logic [SW-1:0]  sroot_w [0:SQN];
  side_t          sside_w [0:SQN];

  assign sq_w[0]    = dq_w[DIVN];
  assign srem_w[0]  = '0;
  assign sroot_w[0] = '0;
  assign sside_w[0] = dside_w[DIVN];

  for (genvar gj = 0; gj < SQN; gj++) begin : g_sqrt
    slpw_sqrt_cell #(.J(SQN - 1 - gj)) u_cell (
      .clk(clk), .en(en),
      .q_i(sq_w[gj]), .rem_i(srem_w[gj]), .root_i(sroot_w[gj]), .side_i(sside_w[gj]),
      .q_o(sq_w[gj+1]), .rem_o(srem_w[gj+1]), .root_o(sroot_w[gj+1]),
      .side_o(sside_w[gj+1])
    );
  end

  // Scale factor.
  logic [SW-1:0] s_r;
  side_t         sides_r;
  side_t         sm_r [0:1];

  always_ff @(posedge clk) begin
    if (en) begin
      s_r     <= sside_w[SQN].zs ? '0 : sroot_w[SQN];
      sides_r <= sside_w[SQN];
      sm_r[0] <= sides_r;
      sm_r[1] <= sm_r[0];
    end
  end

  // Scaled magnitudes.
  logic [AXW+SW-1:0] msx;
  logic [AXW+SW-1:0] msy;

  slpw_mul #(.AW(AXW), .BW(SW)) u_msx (
    .clk(clk), .en(en), .a(sides_r.ax), .b(s_r), .p(msx)
  );
  slpw_mul #(.AW(AXW), .BW(SW)) u_msy (
    .clk(clk), .en(en), .a(sides_r.ay), .b(s_r), .p(msy)
  );

  // Restore the sign and move back by the offsets.
  logic signed [TW-1:0] mxe;
  logic signed [TW-1:0] mye;
  logic signed [TW-1:0] tx_r;
  logic signed [TW-1:0] ty_r;
  logic                 invt_r;

  assign mxe = $signed(TW'(msx[AXW+SW-1:FRAC_BITS]));
  assign mye = $signed(TW'(msy[AXW+SW-1:FRAC_BITS]));

  always_ff @(posedge clk) begin
    if (en) begin
      tx_r   <= (sm_r[1].sx ? -mxe : mxe) + TW'(xoff_r);
      ty_r   <= (sm_r[1].sy ? -mye : mye) + TW'(yoff_r);
      invt_r <= sm_r[1].inv;
    end
  end

  // Back to pixels.
  localparam int PWW = TW + 13;
  logic signed [PWW-1:0] pwx_r;
  logic signed [PWW-1:0] pwy_r;
  logic                  invp_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pwx_r  <= tx_r * $signed({1'b0, width_r});
      pwy_r  <= ty_r * $signed({1'b0, width_r});
      invp_r <= invt_r;
    end
  end

  // Saturate to the output range.
  logic signed [PWW-1:0] shx;
  logic signed [PWW-1:0] shy;
  logic [OW-1:0]         satx;
  logic [OW-1:0]         saty;
  res_t                  res_r;

  assign shx = pwx_r >>> (FRAC_BITS - 8);
  assign shy = pwy_r >>> (FRAC_BITS - 8);

  always_comb begin
    priority if (shx > $signed(PWW'(8388607))) begin
      satx = 24'h7fffff;
    end else if (shx < -$signed(PWW'(8388608))) begin
      satx = 24'h800000;
    end else begin
      satx = shx[OW-1:0];
    end
    priority if (shy > $signed(PWW'(8388607))) begin
      saty = 24'h7fffff;
    end else if (shy < -$signed(PWW'(8388608))) begin
      saty = 24'h800000;
    end else begin
      saty = shy[OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r.x   <= invp_r ? '0 : satx;
      res_r.y   <= invp_r ? '0 : saty;
      res_r.inv <= invp_r;
    end
  end

  // Output register with a skid word behind it.
  logic pv_go;
  logic take;
  res_t out_r;
  res_t skid_r;

  assign pv_go = en && vld_r[LAT-1];
  assign take  = out_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || take) begin
      out_valid_r <= pv_go;
    end else if (pv_go) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) begin
        out_r <= skid_r;
      end
    end else if (!out_valid_r || take) begin
      out_r <= res_r;
    end else if (pv_go) begin
      skid_r <= res_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.y, out_r.x};
  assign out_tuser  = out_r.inv;

  // The skid word is only ever filled behind a waiting output word.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held without an output word");

  // An invalid result carries zero coordinates.
  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.inv) |-> (out_r.x == '0 && out_r.y == '0))
    else $error("invalid result with non-zero coordinates");

  // The pipeline holds its valid bits while stalled.
  a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!en && $past(rst_n)) |=> $stable(vld_r))
    else $error("pipeline moved while stalled");

endmodule
`default_nettype wire
